// ===== sv/circular_double_ended_queue_core_assert.svh =====
// Assertion macros for the deque core RTL.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque check failed");

// Next-cycle implication, checked out of reset.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// ===== sv/cdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Operation codes carried in the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_REAR  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_READ_ALL   = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-cycle command to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_REAR,
        CMD_PUSH_FRONT,
        CMD_POP_FRONT,
        CMD_POP_REAR,
        CMD_ROTATE
    } t_cmd;

    typedef struct packed {
        t_cmd   cmd;
        t_value value;
    } t_chain_ctl;

    typedef struct packed {
        logic   full;
        logic   empty;
        t_value front_value;
        t_value rear_value;
    } t_chain_sts;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

`default_nettype wire

// ===== sv/cdq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One queue slot. Slot k holds the k-th entry counted from the front.
module cdq_cell
    import cdq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_chain_ctl i_ctl,
    input  wire logic       i_left_occ,
    input  wire t_value     i_left_data,
    input  wire logic       i_right_occ,
    input  wire t_value     i_right_data,
    input  wire t_value     i_head_data,
    output logic            o_occ,
    output t_value          o_data,
    output t_value          o_tail_data
);

    logic   r_occ;
    logic   n_occ;
    t_value r_data;
    t_value n_data;
    logic   w_tail;

    // This slot holds the rear entry
    assign w_tail = r_occ && !i_right_occ;

    // Shift, fill or drop according to the command
    always_comb begin
        n_occ  = r_occ;
        n_data = r_data;
        case (i_ctl.cmd)
            CMD_PUSH_FRONT: begin
                n_occ  = i_left_occ;
                n_data = i_left_data;
            end
            CMD_PUSH_REAR: begin
                if (!r_occ && i_left_occ) begin
                    n_occ  = 1'b1;
                    n_data = i_ctl.value;
                end
            end
            CMD_POP_FRONT: begin
                n_occ  = i_right_occ;
                n_data = i_right_data;
            end
            CMD_POP_REAR: begin
                if (w_tail) begin
                    n_occ = 1'b0;
                end
            end
            CMD_ROTATE: begin
                if (r_occ) begin
                    n_data = i_right_occ ? i_right_data : i_head_data;
                end
            end
            default: begin
                n_occ  = r_occ;
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_occ       = r_occ;
    assign o_data      = r_data;
    assign o_tail_data = w_tail ? r_data : '0;

endmodule

`default_nettype wire

// ===== sv/cdq_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Row of slots; entries stay packed toward slot 0, which is the front.
module cdq_chain
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_chain_ctl i_ctl,
    output t_chain_sts      o_sts
);

    logic   w_occ  [DEPTH];
    t_value w_data [DEPTH];
    t_value w_tail [DEPTH];
    t_value w_rear;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic   l_occ;
        t_value l_data;
        logic   r_occ_nb;
        t_value r_data_nb;

        // Left neighbor of the front slot is the new front entry
        if (k == 0) begin : g_first
            assign l_occ  = 1'b1;
            assign l_data = i_ctl.value;
        end else begin : g_left
            assign l_occ  = w_occ[k-1];
            assign l_data = w_data[k-1];
        end

        // Right neighbor of the last slot is always empty
        if (k == DEPTH - 1) begin : g_last
            assign r_occ_nb  = 1'b0;
            assign r_data_nb = '0;
        end else begin : g_right
            assign r_occ_nb  = w_occ[k+1];
            assign r_data_nb = w_data[k+1];
        end

        cdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_left_occ   (l_occ),
            .i_left_data  (l_data),
            .i_right_occ  (r_occ_nb),
            .i_right_data (r_data_nb),
            .i_head_data  (w_data[0]),
            .o_occ        (w_occ[k]),
            .o_data       (w_data[k]),
            .o_tail_data  (w_tail[k])
        );
    end

    // Merge the one-hot rear contributions
    always_comb begin
        w_rear = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rear = w_rear | w_tail[k];
        end
    end

    assign o_sts.full        = w_occ[DEPTH-1];
    assign o_sts.empty       = !w_occ[0];
    assign o_sts.front_value = w_data[0];
    assign o_sts.rear_value  = w_rear;

endmodule

`default_nettype wire

// ===== sv/circular_double_ended_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                   Frame
// s_axis    in   tdata push value, tuser op                none
// m_axis    out  tdata value, tuser status + value valid   tlast on final result
//
// Push and pop each give one result, which sits in the output register.
// Read-out first enters the read state, then emits each stored entry in turn,
// rotating the slot row once per entry so the order is restored; input is held meanwhile.
// An empty read-out gives an empty status; an ignored op gives no result.
// A stall on m_axis holds the output register and the read-out in place.
// Reset (synchronous, active low) empties the queue; slot contents are not cleared.
module circular_double_ended_queue_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [VALUE_W-1:0]  s_axis_tdata,   // [31:0] push_value
    input  wire logic [OP_W-1:0]     s_axis_tuser,   // [2:0] op
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [VALUE_W-1:0]       m_axis_tdata,   // [31:0] out_value
    output logic [STATUS_W:0]        m_axis_tuser,   // [1:0] status, [2] value_valid
    output logic                     m_axis_tlast    // last
);

`include "circular_double_ended_queue_core_assert.svh"

    localparam int CW = $clog2(DEPTH + 1);

    t_state     r_state;
    t_state     n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_left;
    logic [CW-1:0] n_left;

    logic       r_m_valid;
    t_value     r_m_value;
    t_status    r_m_status;
    logic       r_m_vv;
    logic       r_m_last;

    t_chain_ctl w_ctl;
    t_chain_sts w_sts;
    logic       w_out_free;
    logic       w_in_fire;
    logic       w_emit;
    t_status    w_status;
    logic       w_vv;
    t_value     w_value;
    logic       w_last;
    t_op        w_op;

    cdq_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts)
    );

    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tuser);

    // Decode the item, drive the chain, produce any result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        w_ctl.cmd   = CMD_HOLD;
        w_ctl.value = t_value'(s_axis_tdata);
        w_emit      = 1'b0;
        w_status    = ST_OK;
        w_vv        = 1'b0;
        w_value     = '0;
        w_last      = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    case (w_op)
                        OP_PUSH_REAR, OP_PUSH_FRONT: begin
                            w_emit = 1'b1;
                            if (w_sts.full) begin
                                w_status = ST_FULL;
                            end else begin
                                w_ctl.cmd = (w_op == OP_PUSH_REAR) ? CMD_PUSH_REAR
                                                                   : CMD_PUSH_FRONT;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR: begin
                            w_emit = 1'b1;
                            if (w_sts.empty) begin
                                w_status = ST_EMPTY;
                            end else begin
                                w_vv = 1'b1;
                                if (w_op == OP_POP_FRONT) begin
                                    w_ctl.cmd = CMD_POP_FRONT;
                                    w_value   = w_sts.front_value;
                                end else begin
                                    w_ctl.cmd = CMD_POP_REAR;
                                    w_value   = w_sts.rear_value;
                                end
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_READ_ALL: begin
                            if (w_sts.empty) begin
                                w_emit   = 1'b1;
                                w_status = ST_EMPTY;
                            end else begin
                                n_state = S_READ;
                                n_left  = r_count;
                            end
                        end
                        default: begin
                            w_emit = 1'b0;
                        end
                    endcase
                end
            end
            S_READ: begin
                // Emit the front entry and rotate it to the rear
                if (w_out_free) begin
                    w_emit    = 1'b1;
                    w_vv      = 1'b1;
                    w_value   = w_sts.front_value;
                    w_last    = (r_left == CW'(1));
                    w_ctl.cmd = CMD_ROTATE;
                    n_left    = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
        end
    end

    // Output register: load on a new result, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_m_value  <= w_value;
            r_m_status <= w_status;
            r_m_vv     <= w_vv;
            r_m_last   <= w_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_value;
    assign m_axis_tuser  = {r_m_vv, r_m_status};
    assign m_axis_tlast  = r_m_last;

    `CDQ_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `CDQ_ASSERT_IMPL(a_empty_count, i_clk, i_rst_n, 1'b1, w_sts.empty == (r_count == '0))
    `CDQ_ASSERT_IMPL(a_full_count, i_clk, i_rst_n, 1'b1, w_sts.full == (r_count == CW'(DEPTH)))
    `CDQ_ASSERT_NEXT(a_read_end, i_clk, i_rst_n, (r_state == S_READ) && w_emit && w_last, (r_state == S_IDLE) && m_axis_tvalid && m_axis_tlast)

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import cdq_pkg::*;

    localparam int DEPTH        = 8;
    localparam int RANDOM_ITEMS = 100;
    localparam int CYCLE_LIMIT  = 200000;

    // Op codes outside the package enum; the block ignores them
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam t_value VAL_MAX = 32'sh7fff_ffff;
    localparam t_value VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        t_status status;
        logic    value_valid;
        t_value  value;
        logic    last;
    } t_result;

    // One directed step; status_only rows carry their expected status inline
    typedef struct packed {
        logic [OP_W-1:0] op;
        t_value          value;
        logic            status_only;
        t_status         status;
    } t_step;

    localparam int N_DIRECTED = 23;
    localparam t_step DIRECTED [0:N_DIRECTED-1] = '{
        '{OP_READ_ALL,   32'sd0,           1'b1, ST_EMPTY},
        '{OP_POP_FRONT,  32'sd0,           1'b1, ST_EMPTY},
        '{OP_POP_REAR,   32'sd0,           1'b1, ST_EMPTY},
        '{OP_PUSH_REAR,  VAL_MAX,          1'b1, ST_OK},
        '{OP_POP_REAR,   32'sd0,           1'b0, ST_OK},
        '{OP_PUSH_FRONT, VAL_MIN,          1'b1, ST_OK},
        '{OP_PUSH_FRONT, 32'shffff_ffff,   1'b1, ST_OK},
        '{OP_PUSH_REAR,  32'sd0,           1'b1, ST_OK},
        '{OP_PUSH_REAR,  32'sh5555_5555,   1'b1, ST_OK},
        '{OP_PUSH_FRONT, 32'shaaaa_aaaa,   1'b1, ST_OK},
        '{OP_PUSH_REAR,  32'sd1,           1'b1, ST_OK},
        '{OP_PUSH_FRONT, 32'sh1234_5678,   1'b1, ST_OK},
        '{OP_PUSH_REAR,  32'shdead_beef,   1'b1, ST_OK},
        '{OP_PUSH_REAR,  32'sd7,           1'b1, ST_FULL},
        '{OP_PUSH_FRONT, 32'sd9,           1'b1, ST_FULL},
        '{OP_RSVD5,      32'shffff_ffff,   1'b0, ST_OK},
        '{OP_RSVD5 + 3'd1, 32'sd0,         1'b0, ST_OK},
        '{OP_RSVD7,      32'sd3,           1'b0, ST_OK},
        '{OP_READ_ALL,   32'sd0,           1'b0, ST_OK},
        '{OP_POP_FRONT,  32'sd0,           1'b0, ST_OK},
        '{OP_POP_REAR,   32'sd0,           1'b0, ST_OK},
        '{OP_READ_ALL,   32'sd0,           1'b0, ST_OK},
        '{OP_POP_FRONT,  32'sd0,           1'b0, ST_OK}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [VALUE_W-1:0]    s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [VALUE_W-1:0]    m_axis_tdata;
    logic [STATUS_W:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    // Deque shadow state
    t_value  dq_store [DEPTH];
    int      dq_front = 0;
    int      dq_rear  = 0;
    bit      dq_empty = 1'b1;

    t_result predicted [$];
    t_result expected_results [$];
    t_result want;
    int      mismatches  = 0;
    int      cycle_count = 0;
    bit      quiet       = 1'b0;

    circular_double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] push_value
        .s_axis_tuser  (s_axis_tuser),   // [2:0] op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] out_value
        .m_axis_tuser  (m_axis_tuser),   // [1:0] status, [2] value_valid
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int step_up(input int idx);
        return (idx + 1 >= DEPTH) ? 0 : idx + 1;
    endfunction

    function automatic int step_down(input int idx);
        return (idx == 0) ? DEPTH - 1 : idx - 1;
    endfunction

    // Apply one operation to the shadow deque and list the results it gives
    function automatic void predict_deque(input logic [OP_W-1:0] op, input t_value val);
        t_result r;
        int      idx;
        bit      at_end;
        predicted.delete();
        r.status      = ST_OK;
        r.value_valid = 1'b0;
        r.value       = '0;
        r.last        = 1'b1;
        case (op)
            OP_PUSH_REAR, OP_PUSH_FRONT: begin
                if (!dq_empty && step_up(dq_rear) == dq_front) begin
                    r.status = ST_FULL;
                end else if (dq_empty) begin
                    dq_front    = 0;
                    dq_rear     = 0;
                    dq_empty    = 1'b0;
                    dq_store[0] = val;
                end else if (op == OP_PUSH_REAR) begin
                    dq_rear           = step_up(dq_rear);
                    dq_store[dq_rear] = val;
                end else begin
                    dq_front           = step_down(dq_front);
                    dq_store[dq_front] = val;
                end
                predicted.push_back(r);
            end
            OP_POP_FRONT, OP_POP_REAR: begin
                if (dq_empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value_valid = 1'b1;
                    r.value = (op == OP_POP_FRONT) ? dq_store[dq_front] : dq_store[dq_rear];
                    if (dq_front == dq_rear) begin
                        dq_empty = 1'b1;
                        dq_front = 0;
                        dq_rear  = 0;
                    end else if (op == OP_POP_FRONT) begin
                        dq_front = step_up(dq_front);
                    end else begin
                        dq_rear = step_down(dq_rear);
                    end
                end
                predicted.push_back(r);
            end
            OP_READ_ALL: begin
                if (dq_empty) begin
                    r.status = ST_EMPTY;
                    predicted.push_back(r);
                end else begin
                    idx = dq_front;
                    r.value_valid = 1'b1;
                    for (int n = 0; n < DEPTH; n++) begin
                        at_end  = (idx == dq_rear) || (n == DEPTH - 1);
                        r.value = dq_store[idx];
                        r.last  = at_end;
                        predicted.push_back(r);
                        if (at_end) break;
                        idx = step_up(idx);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one item after a random gap and record what it should give
    task automatic send_item(input logic [OP_W-1:0] op, input t_value val,
                             input bit status_only, input t_status status);
        int      gap;
        t_result fixed;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= val;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_deque(op, val);
        if (status_only) begin
            fixed.status      = status;
            fixed.value_valid = 1'b0;
            fixed.value       = '0;
            fixed.last        = 1'b1;
            expected_results.push_back(fixed);
        end else begin
            foreach (predicted[k]) expected_results.push_back(predicted[k]);
        end
    endtask

    // Hold the input off until every outstanding result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Sender: reset, directed steps, then random traffic
    initial begin
        int            accepted_ops;
        int            iter;
        int            roll;
        bit            filling;
        logic [OP_W-1:0] op;
        t_value        val;
        accepted_ops = 0;
        iter         = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_item(DIRECTED[i].op, DIRECTED[i].value,
                      DIRECTED[i].status_only, DIRECTED[i].status);
        end
        drain_results();

        while (accepted_ops < RANDOM_ITEMS) begin
            filling = ((iter / 12) % 2) == 0;
            quiet   = ((iter / 25) % 4) == 3;
            if (iter == 60) drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 5)
                op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
            else if (roll < 15)
                op = OP_READ_ALL;
            else if (roll < (filling ? 75 : 35))
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
            else
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
            case ($urandom_range(0, 9))
                0:       val = VAL_MAX;
                1:       val = VAL_MIN;
                2:       val = '1;
                3:       val = '0;
                default: val = $urandom;
            endcase
            send_item(op, val, 1'b0, ST_OK);
            if (op <= OP_READ_ALL) accepted_ops++;
            iter++;
        end

        // Let every result come back, then watch for strays
        drain_results();
        repeat (DEPTH + 16) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding at end of run");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Receiver: stall a random number of cycles before each result
    initial begin
        int stall;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && m_axis_tvalid));
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser[STATUS_W-1:0] !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tuser[STATUS_W-1:0], want.status));
                if (m_axis_tuser[STATUS_W] !== want.value_valid)
                    report_mismatch($sformatf("value_valid %b, expected %b",
                                              m_axis_tuser[STATUS_W], want.value_valid));
                if (m_axis_tdata !== want.value)
                    report_mismatch($sformatf("value %h, expected %h",
                                              m_axis_tdata, want.value));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              m_axis_tlast, want.last));
            end
        end
    end

endmodule
